// ----- src/cartridge_bank_controller_macros.svh -----
`ifndef CARTRIDGE_BANK_CONTROLLER_MACROS_SVH
`define CARTRIDGE_BANK_CONTROLLER_MACROS_SVH

// same-cycle implication, checked outside reset
`define CBC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CBC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/cbc_pkg.sv -----
`timescale 1ns / 1ps

package cbc_pkg;

	localparam int RTC_REG_COUNT_DEF = 8;

	localparam logic [2:0] KIND_NONE = 3'd0;
	localparam logic [2:0] KIND_MBC1 = 3'd1;
	localparam logic [2:0] KIND_MBC2 = 3'd2;
	localparam logic [2:0] KIND_MBC3 = 3'd3;
	localparam logic [2:0] KIND_MBC5 = 3'd4;

	localparam logic [2:0] TGT_INTERNAL = 3'd0;
	localparam logic [2:0] TGT_ROM      = 3'd1;
	localparam logic [2:0] TGT_RAM      = 3'd2;
	localparam logic [2:0] TGT_RTC      = 3'd3;
	localparam logic [2:0] TGT_NONE     = 3'd4;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	localparam logic [1:0] CFG_KIND   = 2'd0;
	localparam logic [1:0] CFG_WINDOW = 2'd1;

	// mapper register ranges, by address bits 14:13 below 8000
	localparam logic [1:0] REG_RAM_EN  = 2'd0;
	localparam logic [1:0] REG_ROM_SEL = 2'd1;
	localparam logic [1:0] REG_RAM_SEL = 2'd2;
	localparam logic [1:0] REG_MODE    = 2'd3;

	typedef struct packed {
		logic        operation;
		logic [15:0] bus_address;
		logic [7:0]  write_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  target;
		logic [29:0] mapped_offset;
		logic [3:0]  ram_bank_out;
		logic [7:0]  store_byte;
		logic        internal_write;
		logic [7:0]  rtc_read_byte;
	} out_item_t;

	typedef struct packed {
		logic [15:0] rom_bank;
		logic        ram_enabled;
		logic [3:0]  ram_bank;
		logic        upper_rom_mode;
		logic        rtc_mapped;
		logic [2:0]  rtc_index;
		logic        rtc_frozen;
		logic        latch_armed;
	} bank_state_t;

	typedef struct packed {
		logic       en;
		logic [2:0] idx;
		logic [7:0] data;
	} rtc_wr_t;

endpackage

// ----- src/cartridge_bank_controller.sv -----
`timescale 1ns / 1ps
// channel  signals                                   role
// in       in_valid, in_ready, in_data               bus access beat in
// out      out_valid, out_ready, out_data            mapping result beat out
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data register write, always ready
//
// one access per cycle unless out_ready stalls; input register, then result register
// bank state and clock bytes update as an access moves into the result register
// reset sets rom bank 1, clears other bank state, clock bytes, config regs, valid flags
// a stalled out channel holds the result; in_ready drops only when both stages are full
// and out_ready is low

`include "cartridge_bank_controller_macros.svh"

module cartridge_bank_controller #(
	parameter int RTC_REG_COUNT = cbc_pkg::RTC_REG_COUNT_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  cbc_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output cbc_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [13:0]        cfg_data
);

	logic [2:0]           controller_kind_q;
	logic [13:0]          ram_window_q;
	cbc_pkg::in_item_t    item_s1;
	logic                 valid_s1;
	cbc_pkg::out_item_t   res_s2;
	logic                 valid_s2;
	logic                 adv;
	cbc_pkg::bank_state_t state;
	cbc_pkg::bank_state_t state_nxt;
	cbc_pkg::rtc_wr_t     rtc_wr;
	cbc_pkg::out_item_t   result;
	logic [7:0]           rtc_rd_byte;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			controller_kind_q <= cbc_pkg::KIND_NONE;
			ram_window_q      <= 14'd0;
		end else if (cfg_valid) begin
			case (cfg_index)
				cbc_pkg::CFG_KIND:   controller_kind_q <= cfg_data[2:0];
				cbc_pkg::CFG_WINDOW: ram_window_q      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign adv      = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (adv) begin
			res_s2 <= result;
		end
	end

	cbc_bank_regs #(
		.RTC_REG_COUNT(RTC_REG_COUNT)
	) u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.commit     (adv),
		.state_nxt  (state_nxt),
		.rtc_wr     (rtc_wr),
		.state      (state),
		.rtc_rd_byte(rtc_rd_byte)
	);

	cbc_map #(
		.RTC_REG_COUNT(RTC_REG_COUNT)
	) u_map (
		.item            (item_s1),
		.controller_kind (controller_kind_q),
		.ram_window_bytes(ram_window_q),
		.state           (state),
		.rtc_rd_byte     (rtc_rd_byte),
		.state_nxt       (state_nxt),
		.rtc_wr          (rtc_wr),
		.result          (result)
	);

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	`CBC_ASSERT_NEXT(a_adv_shows, adv, valid_s2, "advanced beat missing at result register")
	`CBC_ASSERT_NOW(a_empty_ready, !valid_s1, in_ready, "input stage empty but not ready")
	`CBC_ASSERT_NOW(a_iw_target, valid_s2 && res_s2.internal_write,
		res_s2.target != cbc_pkg::TGT_ROM && res_s2.target != cbc_pkg::TGT_NONE,
		"internal write with rom or register target")
	`CBC_ASSERT_NOW(a_rtc_byte, valid_s2 && res_s2.rtc_read_byte != 8'd0,
		res_s2.target == cbc_pkg::TGT_RTC, "clock byte returned outside clock target")

endmodule

// ----- src/cbc_bank_regs.sv -----
`timescale 1ns / 1ps

module cbc_bank_regs #(
	parameter int RTC_REG_COUNT = cbc_pkg::RTC_REG_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                commit,
	input  cbc_pkg::bank_state_t state_nxt,
	input  cbc_pkg::rtc_wr_t     rtc_wr,
	output cbc_pkg::bank_state_t state,
	output logic [7:0]          rtc_rd_byte
);

	localparam int IDX_W = $clog2(RTC_REG_COUNT);

	cbc_pkg::bank_state_t state_q;
	logic [7:0]           rtc_bytes_q [RTC_REG_COUNT];
	logic                 rd_present;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.rom_bank       <= 16'd1;
			state_q.ram_enabled    <= 1'b0;
			state_q.ram_bank       <= 4'd0;
			state_q.upper_rom_mode <= 1'b0;
			state_q.rtc_mapped     <= 1'b0;
			state_q.rtc_index      <= 3'd0;
			state_q.rtc_frozen     <= 1'b0;
			state_q.latch_armed    <= 1'b0;
		end else if (commit) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RTC_REG_COUNT; i++) begin
				rtc_bytes_q[i] <= 8'd0;
			end
		end else if (commit && rtc_wr.en) begin
			rtc_bytes_q[rtc_wr.idx[IDX_W-1:0]] <= rtc_wr.data;
		end
	end

	// absent clock registers read as all ones
	assign rd_present  = {1'b0, state_q.rtc_index} < 4'(RTC_REG_COUNT);
	assign rtc_rd_byte = rd_present ? rtc_bytes_q[state_q.rtc_index[IDX_W-1:0]] : 8'hff;
	assign state       = state_q;

endmodule

// ----- src/cbc_map.sv -----
`timescale 1ns / 1ps

module cbc_map #(
	parameter int RTC_REG_COUNT = cbc_pkg::RTC_REG_COUNT_DEF
) (
	input  cbc_pkg::in_item_t    item,
	input  logic [2:0]          controller_kind,
	input  logic [13:0]         ram_window_bytes,
	input  cbc_pkg::bank_state_t state,
	input  logic [7:0]          rtc_rd_byte,
	output cbc_pkg::bank_state_t state_nxt,
	output cbc_pkg::rtc_wr_t     rtc_wr,
	output cbc_pkg::out_item_t   result
);

	logic [2:0]  kind;
	logic [15:0] a;
	logic [7:0]  v;
	logic        in_win;
	logic        in_window;
	logic        rtc_present;
	logic        rtc_sel;
	logic [7:0]  bank_lo;

	always_comb begin
		kind        = (controller_kind > cbc_pkg::KIND_MBC5) ? cbc_pkg::KIND_NONE : controller_kind;
		a           = item.bus_address;
		v           = item.write_byte;
		in_win      = (a[15:13] == 3'b101) && state.ram_enabled && (kind != cbc_pkg::KIND_NONE);
		in_window   = {1'b0, a[12:0]} < ram_window_bytes;
		rtc_present = {1'b0, state.rtc_index} < 4'(RTC_REG_COUNT);
		rtc_sel     = (kind == cbc_pkg::KIND_MBC3) && state.rtc_mapped;
		bank_lo     = (v == 8'd0) ? 8'd1 : v;

		state_nxt = state;
		rtc_wr    = '0;
		rtc_wr.idx  = state.rtc_index;
		rtc_wr.data = v;

		result                = '0;
		result.target         = cbc_pkg::TGT_INTERNAL;
		result.mapped_offset  = {14'd0, a};

		if (item.operation == cbc_pkg::OP_WRITE) begin
			if (a[15]) begin
				result.internal_write = 1'b1;
				result.store_byte     = v;
				if (in_win) begin
					if (rtc_sel) begin
						if (!state.rtc_frozen && rtc_present) begin
							rtc_wr.en            = 1'b1;
							result.target        = cbc_pkg::TGT_RTC;
							result.mapped_offset = {27'd0, state.rtc_index};
						end
					end else if (in_window) begin
						if (kind == cbc_pkg::KIND_MBC2) begin
							result.store_byte = {4'd0, v[3:0]};
						end
						result.target        = cbc_pkg::TGT_RAM;
						result.mapped_offset = {17'd0, a[12:0]};
					end
				end
			end else begin
				result.target        = cbc_pkg::TGT_NONE;
				result.mapped_offset = '0;
				if (kind != cbc_pkg::KIND_NONE) begin
					case (a[14:13])
						cbc_pkg::REG_RAM_EN: begin
							if (!(kind == cbc_pkg::KIND_MBC2 && a[8])) begin
								state_nxt.ram_enabled = (v[3:0] == 4'ha);
							end
						end
						cbc_pkg::REG_ROM_SEL: begin
							case (kind)
								cbc_pkg::KIND_MBC1: begin
									state_nxt.rom_bank = {9'd0, state.rom_bank[6:5],
										(v[4:0] == 5'd0) ? 5'd1 : v[4:0]};
								end
								cbc_pkg::KIND_MBC2: begin
									if (a[8]) begin
										state_nxt.rom_bank = {12'd0,
											(v[3:0] == 4'd0) ? 4'd1 : v[3:0]};
									end
								end
								cbc_pkg::KIND_MBC3: begin
									state_nxt.rom_bank = {8'd0, bank_lo};
								end
								default: begin
									if (!a[12]) begin
										state_nxt.rom_bank = {state.rom_bank[15:8], v};
									end else begin
										state_nxt.rom_bank = {v, state.rom_bank[7:0]};
									end
								end
							endcase
						end
						cbc_pkg::REG_RAM_SEL: begin
							case (kind)
								cbc_pkg::KIND_MBC1: begin
									if (state.upper_rom_mode) begin
										state_nxt.rom_bank = {9'd0, v[1:0], state.rom_bank[4:0]};
									end else begin
										state_nxt.ram_bank = {2'd0, v[1:0]};
									end
								end
								cbc_pkg::KIND_MBC3: begin
									if (v[7:3] != 5'd0) begin
										state_nxt.rtc_mapped = 1'b1;
										state_nxt.rtc_index  = v[2:0];
									end else begin
										state_nxt.rtc_mapped = 1'b0;
										state_nxt.ram_bank   = v[3:0];
									end
								end
								cbc_pkg::KIND_MBC5: begin
									state_nxt.ram_bank = v[3:0];
								end
								default: begin
								end
							endcase
						end
						default: begin
							case (kind)
								cbc_pkg::KIND_MBC1: begin
									state_nxt.upper_rom_mode = ~v[0];
								end
								cbc_pkg::KIND_MBC3: begin
									if (state.latch_armed && v == 8'd1) begin
										state_nxt.latch_armed = 1'b0;
										state_nxt.rtc_frozen  = ~state.rtc_frozen;
									end else if (v == 8'd0) begin
										state_nxt.latch_armed = 1'b1;
									end
								end
								default: begin
								end
							endcase
						end
					endcase
				end
			end
		end else if (kind != cbc_pkg::KIND_NONE) begin
			if (a[15:14] == 2'b01) begin
				result.target        = cbc_pkg::TGT_ROM;
				result.mapped_offset = {state.rom_bank, a[13:0]};
			end else if (in_win) begin
				if (rtc_sel) begin
					result.target        = cbc_pkg::TGT_RTC;
					result.mapped_offset = {27'd0, state.rtc_index};
					result.rtc_read_byte = rtc_rd_byte;
				end else if (in_window) begin
					result.target        = cbc_pkg::TGT_RAM;
					result.mapped_offset = {17'd0, a[12:0]};
				end
			end
		end

		result.ram_bank_out = state_nxt.ram_bank;
	end

endmodule
